[design/ttx_pkg.sv]
package ttx_pkg;

  // Item kinds on the input tuser bit
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  // Display modes
  localparam logic [1:0] DMODE_ALPHA    = 2'd0;
  localparam logic [1:0] DMODE_UNUSED   = 2'd3;

  // Height modes
  localparam logic [1:0] HMODE_NORMAL = 2'd0;
  localparam logic [1:0] HMODE_BOTTOM = 2'd1;
  localparam logic [1:0] HMODE_UNUSED = 2'd3;

  localparam int FONT_COUNT = 3;

  // Field widths
  localparam int ROW_W = 5;
  localparam int PIX_W = 16;

  // Input tdata layout, lowest bit first
  localparam int IN_W          = 48;
  localparam int FONT_SEL_LSB  = 0;
  localparam int GLYPH_IDX_LSB = 2;
  localparam int ROW_IDX_LSB   = 9;
  localparam int FONT_WORD_LSB = 14;
  localparam int CHAR_CODE_LSB = 30;
  localparam int DMODE_LSB     = 37;
  localparam int HMODE_LSB     = 39;
  localparam int HOLD_LSB      = 41;

  // Output tdata layout: out_row then pixels
  localparam int OUT_W = 24;

  // Tag travelling alongside a glyph row read
  typedef struct packed {
    logic             blank;
    logic             last;
    logic [ROW_W-1:0] row;
  } row_tag_t;

endpackage

[design/teletext_cell_glyph_renderer.sv]
// Teletext cell glyph renderer.
// Input stream (s_axis_*): tuser picks the kind. A load transfer writes one
// 16-bit glyph row into the font memory if its indices are in range. A render
// transfer takes one character cell and yields CELL_ROWS output transfers.
// Output stream (m_axis_*): one pixel row per transfer with its row number;
// tlast marks the final row of the cell.
// A render transfer starts the sequencer; each row read is registered in
// the font memory read port and then in the output buffer, which offers it.
// The input is held off while the sequencer reads one glyph row per cycle,
// whenever the buffer grants a read credit, from the font memory (one write
// port, one registered read port); a load does not hold off the input.
// A two-slot output buffer with read credits keeps the row reads running
// while rows wait; when the receiver stalls, reads pause and nothing is lost.
// Reset clears the sequencer, the output buffer and the hold-graphics state
// (held glyph blank, previous modes alphanumeric and normal height). The
// font memory is not cleared: rows must be loaded before they are shown.
module teletext_cell_glyph_renderer #(
  parameter int CELL_ROWS       = 20,
  parameter int GLYPH_COUNT     = 96,
  parameter int FIRST_PRINTABLE = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // font_select, glyph_index, row_index, font_word, char_code,
  // display_mode, height_mode, hold_on
  input  logic [ttx_pkg::IN_W-1:0]   s_axis_tdata,
  // mode
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // out_row, pixels
  output logic [ttx_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                       m_axis_tlast
);

  localparam int DEPTH = ttx_pkg::FONT_COUNT * GLYPH_COUNT * CELL_ROWS;
  localparam int AW    = $clog2(DEPTH);

  logic                      mem_we, mem_re, can_issue;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [ttx_pkg::PIX_W-1:0] mem_wdata, mem_rdata, out_pixels;
  logic [ttx_pkg::ROW_W-1:0] out_row;
  ttx_pkg::row_tag_t         rd_tag;

  ttx_cell_ctrl #(
    .CELL_ROWS       (CELL_ROWS),
    .GLYPH_COUNT     (GLYPH_COUNT),
    .FIRST_PRINTABLE (FIRST_PRINTABLE),
    .AW              (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .can_issue (can_issue),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .rd_tag    (rd_tag)
  );

  ttx_font_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ttx_out_buf u_out (
    .clk        (clk),
    .rst        (rst),
    .issue      (mem_re),
    .issue_tag  (rd_tag),
    .rdata      (mem_rdata),
    .can_issue  (can_issue),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_row    (out_row),
    .out_pixels (out_pixels),
    .out_last   (m_axis_tlast)
  );

  // Output packing, padded to whole bytes
  assign m_axis_tdata = {
    (ttx_pkg::OUT_W - ttx_pkg::PIX_W - ttx_pkg::ROW_W)'(0), out_pixels, out_row
  };

endmodule

[design/ttx_font_mem.sv]
module ttx_font_mem #(
  parameter int DEPTH = 5760,
  parameter int AW    = 13
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [ttx_pkg::PIX_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [ttx_pkg::PIX_W-1:0] rdata
);

  logic [ttx_pkg::PIX_W-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ttx_cell_ctrl.sv]
module ttx_cell_ctrl #(
  parameter int CELL_ROWS       = 20,
  parameter int GLYPH_COUNT     = 96,
  parameter int FIRST_PRINTABLE = 32,
  parameter int AW              = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic [ttx_pkg::IN_W-1:0]   in_data,
  input  logic                       can_issue,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [ttx_pkg::PIX_W-1:0]  mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  output ttx_pkg::row_tag_t          rd_tag
);

  localparam int HALF     = CELL_ROWS / 2;
  localparam int LAST_ROW = CELL_ROWS - 1;

  // Field decode
  logic [1:0] f_sel;
  logic [6:0] g_idx;
  logic [4:0] r_idx;
  logic [6:0] code;
  logic [1:0] dmode_raw, hmode_raw, dmode, hmode;
  logic       hold;

  assign f_sel     = in_data[ttx_pkg::FONT_SEL_LSB  +: 2];
  assign g_idx     = in_data[ttx_pkg::GLYPH_IDX_LSB +: 7];
  assign r_idx     = in_data[ttx_pkg::ROW_IDX_LSB   +: 5];
  assign mem_wdata = in_data[ttx_pkg::FONT_WORD_LSB +: ttx_pkg::PIX_W];
  assign code      = in_data[ttx_pkg::CHAR_CODE_LSB +: 7];
  assign dmode_raw = in_data[ttx_pkg::DMODE_LSB     +: 2];
  assign hmode_raw = in_data[ttx_pkg::HMODE_LSB     +: 2];
  assign hold      = in_data[ttx_pkg::HOLD_LSB];

  assign dmode = (dmode_raw == ttx_pkg::DMODE_UNUSED) ? ttx_pkg::DMODE_ALPHA : dmode_raw;
  assign hmode = (hmode_raw == ttx_pkg::HMODE_UNUSED) ? ttx_pkg::HMODE_NORMAL : hmode_raw;

  // Sequencer and held-glyph registers
  logic          busy;
  logic [4:0]    k;
  logic [AW-1:0] base;
  logic [1:0]    cur_hmode;
  logic          cur_blank;
  logic [1:0]    prev_dmode, prev_hmode;
  logic          held_blank;
  logic [1:0]    held_font;
  logic [6:0]    held_glyph;

  logic accept, accept_load, accept_render;
  assign in_ready      = !busy;
  assign accept        = in_valid && !busy;
  assign accept_load   = accept && (in_kind == ttx_pkg::MODE_LOAD);
  assign accept_render = accept && (in_kind != ttx_pkg::MODE_LOAD);

  // Font load write
  logic load_ok;
  assign load_ok = (f_sel < 2'(ttx_pkg::FONT_COUNT)) &&
                   ({1'b0, g_idx} < 8'(GLYPH_COUNT)) &&
                   ({1'b0, r_idx} < 6'(CELL_ROWS));
  assign mem_we    = accept_load && load_ok;
  assign mem_waddr = AW'((32'(f_sel) * GLYPH_COUNT + 32'(g_idx)) * CELL_ROWS + 32'(r_idx));

  // Glyph selection for a render
  logic       is_ctrl, glyph_ok, mode_chg, held_blank_eff, use_held;
  logic [6:0] glyph, show_glyph;
  logic [1:0] show_font;
  logic       show_blank;
  logic [AW-1:0] base_next;

  always_comb begin
    is_ctrl        = {1'b0, code} < 8'(FIRST_PRINTABLE);
    glyph          = is_ctrl ? 7'd0 : code - 7'(FIRST_PRINTABLE);
    glyph_ok       = {1'b0, glyph} < 8'(GLYPH_COUNT);
    mode_chg       = (dmode != prev_dmode) || (hmode != prev_hmode);
    held_blank_eff = held_blank || mode_chg;
    use_held       = is_ctrl && hold;
    if (use_held) begin
      show_blank = held_blank_eff;
      show_font  = held_font;
      show_glyph = held_glyph;
    end else begin
      show_blank = !glyph_ok;
      show_font  = dmode;
      show_glyph = glyph;
    end
    if (show_blank) begin
      base_next = '0;
    end else begin
      base_next = AW'((32'(show_font) * GLYPH_COUNT + 32'(show_glyph)) * CELL_ROWS);
    end
  end

  // Row read issue
  logic [4:0] src;
  logic       last;
  always_comb begin
    case (cur_hmode)
      ttx_pkg::HMODE_NORMAL: src = k;
      ttx_pkg::HMODE_BOTTOM: src = 5'(HALF) + (k >> 1);
      default:               src = k >> 1;
    endcase
  end

  assign last         = (k == 5'(LAST_ROW));
  assign mem_re       = busy && can_issue;
  assign mem_raddr    = base + AW'(src);
  assign rd_tag.blank = cur_blank;
  assign rd_tag.last  = last;
  assign rd_tag.row   = k;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      k          <= '0;
      prev_dmode <= ttx_pkg::DMODE_ALPHA;
      prev_hmode <= ttx_pkg::HMODE_NORMAL;
      held_blank <= 1'b1;
      held_font  <= '0;
      held_glyph <= '0;
    end else if (accept_render) begin
      busy       <= 1'b1;
      k          <= '0;
      prev_dmode <= dmode;
      prev_hmode <= hmode;
      if (!is_ctrl && (dmode != ttx_pkg::DMODE_ALPHA)) begin
        if (glyph_ok) begin
          held_blank <= 1'b0;
          held_font  <= dmode;
          held_glyph <= glyph;
        end else begin
          held_blank <= 1'b1;
        end
      end else begin
        held_blank <= held_blank_eff;
      end
    end else if (mem_re) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        k <= k + 5'd1;
      end
    end
  end

  // Per-cell payload
  always_ff @(posedge clk) begin
    if (accept_render) begin
      base      <= base_next;
      cur_hmode <= hmode;
      cur_blank <= show_blank;
    end
  end

endmodule

[design/ttx_out_buf.sv]
module ttx_out_buf (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       issue,
  input  ttx_pkg::row_tag_t          issue_tag,
  input  logic [ttx_pkg::PIX_W-1:0]  rdata,
  output logic                       can_issue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ttx_pkg::ROW_W-1:0]  out_row,
  output logic [ttx_pkg::PIX_W-1:0]  out_pixels,
  output logic                       out_last
);

  typedef struct packed {
    logic [ttx_pkg::PIX_W-1:0] pixels;
    logic [ttx_pkg::ROW_W-1:0] row;
    logic                      last;
  } out_entry_t;

  logic              inflight;
  ttx_pkg::row_tag_t tag_q;
  logic [1:0]        occ;
  out_entry_t        e0, e1, fresh;
  logic              push, pop;

  // Row read returns in the cycle after its issue
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 1'b0;
    end else begin
      inflight <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      tag_q <= issue_tag;
    end
  end

  assign fresh.pixels = tag_q.blank ? '0 : rdata;
  assign fresh.row    = tag_q.row;
  assign fresh.last   = tag_q.last;

  assign push      = inflight;
  assign pop       = out_valid && out_ready;
  assign out_valid = (occ != 2'd0);

  // Two slots: a read may be issued only if its row is sure to find room
  assign can_issue = (({1'b0, occ} + {2'b0, inflight}) < 3'd2) || pop;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (push && !pop) begin
      occ <= occ + 2'd1;
    end else if (pop && !push) begin
      occ <= occ - 2'd1;
    end
  end

  // Slot data
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (occ == 2'd1) begin
        e0 <= fresh;
      end else begin
        e0 <= e1;
        e1 <= fresh;
      end
    end else if (pop) begin
      e0 <= e1;
    end else if (push) begin
      if (occ == 2'd0) begin
        e0 <= fresh;
      end else begin
        e1 <= fresh;
      end
    end
  end

  assign out_row    = e0.row;
  assign out_pixels = e0.pixels;
  assign out_last   = e0.last;

endmodule

[design/ttx_checker.sv]
module ttx_checker #(
  parameter int CELL_ROWS = 20
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [ttx_pkg::IN_W-1:0]  s_axis_tdata,
  input logic                      s_axis_tuser,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [ttx_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);

  // Nothing is offered straight out of reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A stalled row holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output row changed");

  // tlast sits exactly on the final row number
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tlast == (m_axis_tdata[ttx_pkg::ROW_W-1:0] == ttx_pkg::ROW_W'(CELL_ROWS - 1))))
    else $error("tlast does not match row number");

  // Row number stays within the cell
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[ttx_pkg::ROW_W-1:0] < ttx_pkg::ROW_W'(CELL_ROWS - 1))
                      || m_axis_tlast)
    else $error("row number beyond cell");

  // An accepted render drops the input ready
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ttx_pkg::MODE_RENDER)
      |=> !s_axis_tready)
    else $error("input ready during a render");

endmodule

bind teletext_cell_glyph_renderer ttx_checker #(.CELL_ROWS(CELL_ROWS)) u_ttx_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[bench/glyph_row_checker.sv]
`timescale 1ns / 1ps

// Watches both streams of the glyph renderer, predicts the pixel rows of
// every accepted cell and compares each row transfer with the oldest one due.
module glyph_row_checker #(
  parameter int CELL_ROWS       = 20,
  parameter int GLYPH_COUNT     = 96,
  parameter int FIRST_PRINTABLE = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [ttx_pkg::IN_W-1:0]  s_tdata,
  input  logic                      s_tuser,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [ttx_pkg::OUT_W-1:0] m_tdata,
  input  logic                      m_tlast,
  output int                        error_count,
  output int                        rows_pending
);

  localparam int STORE_DEPTH = ttx_pkg::FONT_COUNT * GLYPH_COUNT * CELL_ROWS;

  typedef struct packed {
    logic [ttx_pkg::ROW_W-1:0] row;
    logic [ttx_pkg::PIX_W-1:0] pixels;
    logic                      last;
  } pixel_row_t;

  // Own copy of the font memory and of the hold-graphics state
  logic [ttx_pkg::PIX_W-1:0] font_rows [STORE_DEPTH];
  logic [1:0]                prev_dmode;
  logic [1:0]                prev_hmode;
  logic                      held_blank;
  logic [1:0]                held_font;
  int                        held_glyph;

  pixel_row_t       expected_rows [$];
  int               mismatches = 0;

  function automatic logic [ttx_pkg::PIX_W-1:0] font_row(int f, int g, int r);
    if (f >= ttx_pkg::FONT_COUNT || g >= GLYPH_COUNT || r >= CELL_ROWS)
      return '0;
    return font_rows[(f * GLYPH_COUNT + g) * CELL_ROWS + r];
  endfunction

  task automatic store_font_row(input logic [ttx_pkg::IN_W-1:0] d);
    int f;
    int g;
    int r;
    f = d[ttx_pkg::FONT_SEL_LSB +: 2];
    g = d[ttx_pkg::GLYPH_IDX_LSB +: 7];
    r = d[ttx_pkg::ROW_IDX_LSB +: ttx_pkg::ROW_W];
    // out-of-range loads are dropped
    if (f < ttx_pkg::FONT_COUNT && g < GLYPH_COUNT && r < CELL_ROWS)
      font_rows[(f * GLYPH_COUNT + g) * CELL_ROWS + r] =
        d[ttx_pkg::FONT_WORD_LSB +: ttx_pkg::PIX_W];
  endtask

  task automatic predict_cell_rows(input logic [ttx_pkg::IN_W-1:0] d);
    logic [6:0] code;
    logic [1:0] dm;
    logic [1:0] hm;
    logic       hold;
    logic       is_ctrl;
    logic       show_blank;
    logic [1:0] show_font;
    int         glyph;
    int         show_glyph;
    int         base;
    int         src;
    pixel_row_t r;
    code = d[ttx_pkg::CHAR_CODE_LSB +: 7];
    dm   = d[ttx_pkg::DMODE_LSB +: 2];
    hm   = d[ttx_pkg::HMODE_LSB +: 2];
    hold = d[ttx_pkg::HOLD_LSB];
    if (dm == ttx_pkg::DMODE_UNUSED) dm = ttx_pkg::DMODE_ALPHA;
    if (hm == ttx_pkg::HMODE_UNUSED) hm = ttx_pkg::HMODE_NORMAL;
    is_ctrl = code < FIRST_PRINTABLE;
    glyph   = is_ctrl ? 0 : int'(code) - FIRST_PRINTABLE;

    // a change of either mode drops the held mosaic
    if (dm != prev_dmode || hm != prev_hmode)
      held_blank = 1'b1;

    if (is_ctrl && hold) begin
      show_blank = held_blank;
      show_font  = held_font;
      show_glyph = held_glyph;
    end else begin
      show_blank = glyph >= GLYPH_COUNT;
      show_font  = dm;
      show_glyph = glyph;
    end

    // printable codes in graphics modes (space too) become the held glyph
    if (!is_ctrl && dm != ttx_pkg::DMODE_ALPHA) begin
      if (glyph < GLYPH_COUNT) begin
        held_blank = 1'b0;
        held_font  = dm;
        held_glyph = glyph;
      end else begin
        held_blank = 1'b1;
      end
    end
    prev_dmode = dm;
    prev_hmode = hm;

    base = (hm == ttx_pkg::HMODE_BOTTOM) ? CELL_ROWS / 2 : 0;
    for (int k = 0; k < CELL_ROWS; k++) begin
      src      = (hm == ttx_pkg::HMODE_NORMAL) ? k : base + k / 2;
      r.row    = ttx_pkg::ROW_W'(k);
      r.pixels = show_blank ? '0 : font_row(show_font, show_glyph, src);
      r.last   = (k == CELL_ROWS - 1);
      expected_rows.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    pixel_row_t want;
    logic [ttx_pkg::ROW_W-1:0] got_row;
    logic [ttx_pkg::PIX_W-1:0] got_pixels;
    if (rst) begin
      prev_dmode = ttx_pkg::DMODE_ALPHA;
      prev_hmode = ttx_pkg::HMODE_NORMAL;
      held_blank = 1'b1;
      held_font  = '0;
      held_glyph = 0;
      expected_rows.delete();
    end else begin
      // output side first: a new cell's rows never leave on its own edge
      if (m_tvalid && m_tready) begin
        got_row    = m_tdata[ttx_pkg::ROW_W-1:0];
        got_pixels = m_tdata[ttx_pkg::ROW_W +: ttx_pkg::PIX_W];
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: row transfer with none due: row %0d pixels %h last %b",
                     $time, got_row, got_pixels, m_tlast);
        end else begin
          want = expected_rows.pop_front();
          if (got_row !== want.row || got_pixels !== want.pixels ||
              m_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected row %0d pixels %h last %b, got %0d %h %b",
                       $time, want.row, want.pixels, want.last,
                       got_row, got_pixels, m_tlast);
          end
        end
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser == ttx_pkg::MODE_LOAD)
          store_font_row(s_tdata);
        else
          predict_cell_rows(s_tdata);
      end
    end
    error_count  <= mismatches;
    rows_pending <= expected_rows.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

// Fills a few glyphs of every font, runs a directed set of cells through the
// hold and height logic, then random screen rows of cells mixed with font
// loads. Rendered codes stay within the filled glyphs.
module tb;

  localparam int CELL_ROWS       = 20;
  localparam int GLYPH_COUNT     = 96;
  localparam int FIRST_PRINTABLE = 32;
  localparam int FILL_COUNT      = 3;
  localparam int RANDOM_ITEMS    = 200;
  localparam int CYCLE_LIMIT     = 400000;

  // Graphics and height codes not named in the package
  localparam logic [1:0] DMODE_CONTIG = 2'd1;
  localparam logic [1:0] DMODE_SEP    = 2'd2;
  localparam logic [1:0] HMODE_TOP    = 2'd2;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [ttx_pkg::IN_W-1:0]  s_axis_tdata = '0;
  logic                      s_axis_tuser = ttx_pkg::MODE_LOAD;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [ttx_pkg::OUT_W-1:0] m_axis_tdata;
  logic                      m_axis_tlast;

  int   error_count;
  int   rows_pending;
  int   cycle_count;
  logic no_idle = 1'b0;

  always #10 clk = ~clk;

  teletext_cell_glyph_renderer #(
    .CELL_ROWS      (CELL_ROWS),
    .GLYPH_COUNT    (GLYPH_COUNT),
    .FIRST_PRINTABLE(FIRST_PRINTABLE)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  glyph_row_checker #(
    .CELL_ROWS      (CELL_ROWS),
    .GLYPH_COUNT    (GLYPH_COUNT),
    .FIRST_PRINTABLE(FIRST_PRINTABLE)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tuser     (s_axis_tuser),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .m_tlast     (m_axis_tlast),
    .error_count (error_count),
    .rows_pending(rows_pending)
  );

  // Receiver stalls at random outside the quiet window
  always @(posedge clk)
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 28);

  // Glyphs filled in every font: the space, one middle glyph and the last one
  function automatic int fill_glyph(input int i);
    case (i)
      0:       return 0;
      1:       return 33;
      default: return GLYPH_COUNT - 1;
    endcase
  endfunction

  // One input transfer, with a random gap ahead of it
  task automatic send_item(input logic kind, input logic [ttx_pkg::IN_W-1:0] d);
    while (!no_idle && $urandom_range(0, 99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_load(input logic [1:0] f, input logic [6:0] g,
                           input logic [4:0] r, input logic [15:0] w);
    logic [ttx_pkg::IN_W-1:0] d;
    d = '0;
    d[ttx_pkg::FONT_SEL_LSB +: 2]               = f;
    d[ttx_pkg::GLYPH_IDX_LSB +: 7]              = g;
    d[ttx_pkg::ROW_IDX_LSB +: ttx_pkg::ROW_W]   = r;
    d[ttx_pkg::FONT_WORD_LSB +: ttx_pkg::PIX_W] = w;
    send_item(ttx_pkg::MODE_LOAD, d);
  endtask

  task automatic send_char(input logic [6:0] code, input logic [1:0] dm,
                           input logic [1:0] hm, input logic hold);
    logic [ttx_pkg::IN_W-1:0] d;
    d = '0;
    d[ttx_pkg::CHAR_CODE_LSB +: 7] = code;
    d[ttx_pkg::DMODE_LSB +: 2]     = dm;
    d[ttx_pkg::HMODE_LSB +: 2]     = hm;
    d[ttx_pkg::HOLD_LSB]           = hold;
    send_item(ttx_pkg::MODE_RENDER, d);
  endtask

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int         sent;
    int         run_len;
    int         pick;
    logic [1:0] dm;
    logic [1:0] hm;
    logic       run_hold;
    logic [6:0] code;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every row of the glyphs that get rendered
    for (int f = 0; f < ttx_pkg::FONT_COUNT; f++)
      for (int i = 0; i < FILL_COUNT; i++)
        for (int r = 0; r < CELL_ROWS; r++)
          send_load(2'(f), 7'(fill_glyph(i)), 5'(r), 16'($urandom));

    // Held glyph still blank from reset
    send_char(7'd0, ttx_pkg::DMODE_ALPHA, ttx_pkg::HMODE_NORMAL, 1'b1);
    // Load field extremes, and loads that must be dropped
    send_load(2'd0, 7'd0, 5'd0, 16'hFFFF);
    send_load(2'd2, 7'd95, 5'd19, 16'h0000);
    send_load(2'd3, 7'd10, 5'd3, 16'hA5A5);
    send_load(2'd1, 7'd127, 5'd3, 16'h5A5A);
    send_load(2'd1, 7'd96, 5'd3, 16'h5A5A);
    send_load(2'd0, 7'd0, 5'd31, 16'h1234);
    send_load(2'd0, 7'd0, 5'd20, 16'h4321);
    // Control code without hold shows the space
    send_char(7'd5, ttx_pkg::DMODE_ALPHA, ttx_pkg::HMODE_NORMAL, 1'b0);
    // Last separated glyph, then held under a control code
    send_char(7'd127, DMODE_SEP, ttx_pkg::HMODE_NORMAL, 1'b0);
    send_char(7'd31, DMODE_SEP, ttx_pkg::HMODE_NORMAL, 1'b1);
    // Height change blanks the held glyph
    send_char(7'd0, DMODE_SEP, HMODE_TOP, 1'b1);
    // Space is a mosaic and gets held; top half doubling
    send_char(7'd32, DMODE_CONTIG, HMODE_TOP, 1'b0);
    send_char(7'd10, DMODE_CONTIG, HMODE_TOP, 1'b1);
    // Bottom half doubling
    send_char(7'd65, DMODE_CONTIG, ttx_pkg::HMODE_BOTTOM, 1'b0);
    send_char(7'd20, DMODE_CONTIG, ttx_pkg::HMODE_BOTTOM, 1'b1);
    // Alphanumeric character is never held; mode change blanks
    send_char(7'd65, ttx_pkg::DMODE_ALPHA, ttx_pkg::HMODE_BOTTOM, 1'b0);
    send_char(7'd1, ttx_pkg::DMODE_ALPHA, ttx_pkg::HMODE_BOTTOM, 1'b1);
    // Unused display and height modes act as alphanumeric and normal
    send_char(7'd127, ttx_pkg::DMODE_UNUSED, ttx_pkg::HMODE_UNUSED, 1'b0);
    send_char(7'd65, DMODE_CONTIG, ttx_pkg::HMODE_UNUSED, 1'b0);
    send_char(7'd2, DMODE_CONTIG, ttx_pkg::HMODE_NORMAL, 1'b1);
    send_char(7'd3, ttx_pkg::DMODE_UNUSED, ttx_pkg::HMODE_NORMAL, 1'b1);

    // Random screen rows: runs of cells sharing modes, font loads between
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      dm = (pick < 20) ? ttx_pkg::DMODE_ALPHA : (pick < 50) ? DMODE_CONTIG :
           (pick < 85) ? DMODE_SEP : ttx_pkg::DMODE_UNUSED;
      pick = $urandom_range(0, 99);
      hm = (pick < 50) ? ttx_pkg::HMODE_NORMAL : (pick < 70) ? ttx_pkg::HMODE_BOTTOM :
           (pick < 90) ? HMODE_TOP : ttx_pkg::HMODE_UNUSED;
      run_hold = $urandom_range(0, 99) < 70;
      run_len  = $urandom_range(1, 12);
      for (int i = 0; i < run_len; i++) begin
        no_idle <= (sent >= 60 && sent < 120);
        if ($urandom_range(0, 99) < 12) begin
          if ($urandom_range(0, 99) < 80)
            send_load(2'($urandom_range(0, 2)), 7'($urandom_range(0, GLYPH_COUNT - 1)),
                      5'($urandom_range(0, CELL_ROWS - 1)), 16'($urandom));
          else
            send_load(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                      5'($urandom_range(0, 31)), 16'($urandom));
          sent++;
        end
        // occasional mode change inside a run
        if ($urandom_range(0, 99) < 8) dm = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 8) hm = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 55)
          code = 7'(FIRST_PRINTABLE + fill_glyph($urandom_range(0, FILL_COUNT - 1)));
        else
          code = 7'($urandom_range(0, FIRST_PRINTABLE - 1));
        send_char(code, dm, hm,
                  run_hold ? ($urandom_range(0, 99) < 80) : 1'($urandom_range(0, 1)));
        sent++;
      end
    end

    // Drain
    s_axis_tvalid <= 1'b0;
    no_idle       <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (4 * CELL_ROWS) @(posedge clk);

    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
